[rtl/acr_pkg.sv]
`timescale 1ns / 1ps
package acr_pkg;

  // fixed field widths
  localparam int VEL_W  = 32;
  localparam int MASS_W = 31;
  localparam int BNC_W  = 17;
  localparam int GAP_W  = 33;
  localparam int SUM_W  = 32;

  // inverse-mass shares are unsigned q.30
  localparam int QW = 30;
  localparam logic [QW:0] SHARE_ONE = (QW+1)'(1) << QW;

  // floor(x / 5) as (x * DIV5_MUL) >> DIV5_SHIFT, exact for x below 2^34
  localparam logic [31:0] DIV5_MUL   = 32'd3435973837;
  localparam int          DIV5_SHIFT = 34;

  // contact normal codes
  localparam logic [1:0] NRM_POS_X = 2'd0;
  localparam logic [1:0] NRM_NEG_X = 2'd1;
  localparam logic [1:0] NRM_POS_Y = 2'd2;
  localparam logic [1:0] NRM_NEG_Y = 2'd3;

  // per-item contact data carried alongside the share divider
  typedef struct packed {
    logic                     hit;
    logic                     stat;
    logic                     axis;
    logic                     pos;
    logic [1:0]               code;
    logic signed [VEL_W-1:0]  pen;
    logic [MASS_W-1:0]        pdepth;
    logic                     apply;
    logic                     corr;
    logic signed [VEL_W-1:0]  vax;
    logic signed [VEL_W-1:0]  vay;
    logic signed [VEL_W-1:0]  vbx;
    logic signed [VEL_W-1:0]  vby;
    logic                     ma0;
    logic                     mb0;
  } acr_mid_t;

endpackage

[rtl/acr_front.sv]
`timescale 1ns / 1ps
module acr_front #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [31:0]         in_offset_x,
  input  logic signed [31:0]         in_offset_y,
  input  logic [30:0]                in_extent_sum_x,
  input  logic [30:0]                in_extent_sum_y,
  input  logic signed [31:0]         in_vel_a_x,
  input  logic signed [31:0]         in_vel_a_y,
  input  logic signed [31:0]         in_vel_b_x,
  input  logic signed [31:0]         in_vel_b_y,
  input  logic [30:0]                in_mass_a,
  input  logic [30:0]                in_mass_b,
  input  logic [16:0]                in_bounce_a,
  input  logic [16:0]                in_bounce_b,
  output logic                       out_valid,
  output acr_pkg::acr_mid_t          out_mid,
  output logic [33 + ((FRACTION_BITS >= 17) ? FRACTION_BITS + 1 : 18)
                - FRACTION_BITS - 1:0] out_d,
  output logic [31:0]                out_sum,
  output logic [30:0]                out_mb
);
  import acr_pkg::*;

  localparam int OW = (FRACTION_BITS >= 17) ? FRACTION_BITS + 1 : 18;
  localparam int DW = 33 + OW - FRACTION_BITS;
  localparam int PW = 33 + OW;
  localparam logic [OW-1:0]     ONE_FIX = OW'(1) << FRACTION_BITS;
  localparam logic [MASS_W-1:0] SLOP    = MASS_W'(((2 ** FRACTION_BITS) + 50) / 100);

  // stage 1 registers
  logic                     v1_r;
  logic signed [GAP_W-1:0]  gx1_r, gy1_r, relx1_r, rely1_r;
  logic                     posx1_r, posy1_r, ma01_r, mb01_r;
  logic [BNC_W-1:0]         e1_r;
  logic [SUM_W-1:0]         sum1_r;
  logic [MASS_W-1:0]        mb1_r;
  logic signed [VEL_W-1:0]  vax1_r, vay1_r, vbx1_r, vby1_r;

  // stage 2 registers
  logic                     v2_r;
  acr_mid_t                 mid2_r;
  logic [32:0]              negvn2_r;
  logic [OW-1:0]            onepe2_r;
  logic [SUM_W-1:0]         sum2_r;
  logic [MASS_W-1:0]        mb2_r;

  // stage 3 registers
  logic                     v3_r;
  acr_mid_t                 mid3_r;
  logic [DW-1:0]            d3_r;
  logic [SUM_W-1:0]         sum3_r;
  logic [MASS_W-1:0]        mb3_r;

  // stage 1: gaps, relative velocities, mass sum, lower bounciness
  logic signed [GAP_W-1:0] oxe, oye, oxa, oya, gx1_nxt, gy1_nxt;
  logic signed [GAP_W-1:0] relx1_nxt, rely1_nxt;
  logic [BNC_W-1:0]        e1_nxt;
  logic [SUM_W-1:0]        sum1_nxt;

  always_comb begin
    oxe       = {in_offset_x[31], in_offset_x};
    oye       = {in_offset_y[31], in_offset_y};
    oxa       = oxe[GAP_W-1] ? -oxe : oxe;
    oya       = oye[GAP_W-1] ? -oye : oye;
    gx1_nxt   = oxa - $signed({2'b00, in_extent_sum_x});
    gy1_nxt   = oya - $signed({2'b00, in_extent_sum_y});
    relx1_nxt = {in_vel_b_x[31], in_vel_b_x} - {in_vel_a_x[31], in_vel_a_x};
    rely1_nxt = {in_vel_b_y[31], in_vel_b_y} - {in_vel_a_y[31], in_vel_a_y};
    e1_nxt    = (in_bounce_a < in_bounce_b) ? in_bounce_a : in_bounce_b;
    sum1_nxt  = {1'b0, in_mass_a} + {1'b0, in_mass_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx1_r   <= gx1_nxt;
      gy1_r   <= gy1_nxt;
      relx1_r <= relx1_nxt;
      rely1_r <= rely1_nxt;
      posx1_r <= !in_offset_x[31] && (in_offset_x != 32'sd0);
      posy1_r <= !in_offset_y[31] && (in_offset_y != 32'sd0);
      ma01_r  <= (in_mass_a == '0);
      mb01_r  <= (in_mass_b == '0);
      e1_r    <= e1_nxt;
      sum1_r  <= sum1_nxt;
      mb1_r   <= in_mass_b;
      vax1_r  <= in_vel_a_x;
      vay1_r  <= in_vel_a_y;
      vbx1_r  <= in_vel_b_x;
      vby1_r  <= in_vel_b_y;
    end
  end

  // stage 2: hit test, axis of least overlap, approach test
  acr_mid_t                mid2_nxt;
  logic signed [GAP_W-1:0] pen33, rel;
  logic signed [33:0]      vn, negvn;
  logic [OW-1:0]           onepe2_nxt;

  always_comb begin
    mid2_nxt      = '0;
    mid2_nxt.hit  = gx1_r[GAP_W-1] && gy1_r[GAP_W-1];
    mid2_nxt.axis = !(gx1_r > gy1_r);
    mid2_nxt.pos  = mid2_nxt.axis ? posy1_r : posx1_r;
    pen33         = mid2_nxt.axis ? gy1_r : gx1_r;
    rel           = mid2_nxt.axis ? rely1_r : relx1_r;
    vn            = mid2_nxt.pos ? {rel[GAP_W-1], rel} : -{rel[GAP_W-1], rel};
    negvn         = -vn;
    mid2_nxt.stat = mid2_nxt.hit && ma01_r && mb01_r;
    mid2_nxt.apply = mid2_nxt.hit && !mid2_nxt.stat && (vn[33] || (vn == 34'sd0));
    if (!mid2_nxt.hit) begin
      mid2_nxt.code = NRM_POS_X;
    end else if (mid2_nxt.axis) begin
      mid2_nxt.code = mid2_nxt.pos ? NRM_POS_Y : NRM_NEG_Y;
    end else begin
      mid2_nxt.code = mid2_nxt.pos ? NRM_POS_X : NRM_NEG_X;
    end
    mid2_nxt.pen    = mid2_nxt.hit ? pen33[VEL_W-1:0] : 32'sd0;
    mid2_nxt.pdepth = MASS_W'(-pen33);
    mid2_nxt.corr   = mid2_nxt.apply && (mid2_nxt.pdepth > SLOP);
    mid2_nxt.vax    = vax1_r;
    mid2_nxt.vay    = vay1_r;
    mid2_nxt.vbx    = vbx1_r;
    mid2_nxt.vby    = vby1_r;
    mid2_nxt.ma0    = ma01_r;
    mid2_nxt.mb0    = mb01_r;
    onepe2_nxt      = ONE_FIX + OW'(e1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid2_r   <= mid2_nxt;
      negvn2_r <= negvn[32:0];
      onepe2_r <= onepe2_nxt;
      sum2_r   <= sum1_r;
      mb2_r    <= mb1_r;
    end
  end

  // stage 3: velocity change magnitude, -vn * (1 + e)
  logic [PW-1:0] prod;

  assign prod = negvn2_r * onepe2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid3_r <= mid2_r;
      d3_r   <= prod[PW-1:FRACTION_BITS];
      sum3_r <= sum2_r;
      mb3_r  <= mb2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_mid   = mid3_r;
  assign out_d     = d3_r;
  assign out_sum   = sum3_r;
  assign out_mb    = mb3_r;

endmodule

[rtl/acr_div.sv]
`timescale 1ns / 1ps
module acr_div #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [30:0]      in_num,
  input  logic [31:0]      in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [29:0]      out_quo,
  output logic             out_rem_nz,
  output logic [TAG_W-1:0] out_tag
);
  import acr_pkg::*;

  // one quotient bit per stage, restoring, most significant bit first
  logic             vld_r [QW];
  logic [31:0]      rem_r [QW];
  logic [31:0]      den_r [QW];
  logic [QW-1:0]    quo_r [QW];
  logic [TAG_W-1:0] tag_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic             v_src;
    logic [31:0]      rem_src, den_src;
    logic [QW-1:0]    quo_src;
    logic [TAG_W-1:0] tag_src;
    logic [32:0]      shl;
    logic [33:0]      diff;
    logic             ge;

    if (i == 0) begin : g_first
      always_comb begin
        v_src   = in_valid;
        rem_src = {1'b0, in_num};
        den_src = in_den;
        quo_src = '0;
        tag_src = in_tag;
      end
    end else begin : g_next
      always_comb begin
        v_src   = vld_r[i-1];
        rem_src = rem_r[i-1];
        den_src = den_r[i-1];
        quo_src = quo_r[i-1];
        tag_src = tag_r[i-1];
      end
    end

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
      shl  = {rem_src, 1'b0};
      diff = {1'b0, shl} - {2'b00, den_src};
      ge   = !diff[33];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[31:0] : shl[31:0];
        den_r[i] <= den_src;
        quo_r[i] <= {quo_src[QW-2:0], ge};
        tag_r[i] <= tag_src;
      end
    end
  end

  assign out_valid  = vld_r[QW-1];
  assign out_quo    = quo_r[QW-1];
  assign out_rem_nz = |rem_r[QW-1];
  assign out_tag    = tag_r[QW-1];

endmodule

[rtl/acr_back.sv]
`timescale 1ns / 1ps
module acr_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  acr_pkg::acr_mid_t   in_mid,
  input  logic [33 + ((FRACTION_BITS >= 17) ? FRACTION_BITS + 1 : 18)
                - FRACTION_BITS - 1:0] in_d,
  input  logic [29:0]         in_quo,
  input  logic                in_rem_nz,
  output logic                out_valid,
  output logic                out_hit,
  output logic [1:0]          out_normal_code,
  output logic signed [31:0]  out_penetration,
  output logic signed [31:0]  out_new_vel_a_x,
  output logic signed [31:0]  out_new_vel_a_y,
  output logic signed [31:0]  out_new_vel_b_x,
  output logic signed [31:0]  out_new_vel_b_y,
  output logic signed [31:0]  out_shift_a_x,
  output logic signed [31:0]  out_shift_a_y,
  output logic signed [31:0]  out_shift_b_x,
  output logic signed [31:0]  out_shift_b_y,
  output logic                out_both_static
);
  import acr_pkg::*;

  localparam int OW = (FRACTION_BITS >= 17) ? FRACTION_BITS + 1 : 18;
  localparam int DW = 33 + OW - FRACTION_BITS;
  localparam int LW = DW / 2;
  localparam int HW = DW - LW;
  localparam int RW = QW + 1;
  localparam int SX = DW + 2;
  localparam int QPW = MASS_W + 32;

  // stage 0: shares of a and b
  logic           v0_r;
  acr_mid_t       mid0_r;
  logic [DW-1:0]  d0_r;
  logic [RW-1:0]  ra0_r, rb0_r;
  logic [RW-1:0]  ra_nxt, rb_nxt;

  always_comb begin
    if (in_mid.ma0) begin
      ra_nxt = '0;
      rb_nxt = SHARE_ONE;
    end else if (in_mid.mb0) begin
      ra_nxt = SHARE_ONE;
      rb_nxt = '0;
    end else begin
      ra_nxt = {1'b0, in_quo};
      rb_nxt = SHARE_ONE - {1'b0, in_quo} - RW'(in_rem_nz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid0_r <= in_mid;
      d0_r   <= in_d;
      ra0_r  <= ra_nxt;
      rb0_r  <= rb_nxt;
    end
  end

  // stage 1: partial products of the shares
  logic                 v1_r;
  acr_mid_t             mid1_r;
  logic [LW+RW-1:0]     pal1_r, pbl1_r;
  logic [HW+RW-1:0]     pah1_r, pbh1_r;
  logic [MASS_W+RW-1:0] ppa1_r, ppb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid1_r <= mid0_r;
      pal1_r <= d0_r[LW-1:0] * ra0_r;
      pah1_r <= d0_r[DW-1:LW] * ra0_r;
      pbl1_r <= d0_r[LW-1:0] * rb0_r;
      pbh1_r <= d0_r[DW-1:LW] * rb0_r;
      ppa1_r <= mid0_r.pdepth * ra0_r;
      ppb1_r <= mid0_r.pdepth * rb0_r;
    end
  end

  // stage 2: combine partial products, drop the share fraction
  logic               v2_r;
  acr_mid_t           mid2_r;
  logic [DW-1:0]      sca2_r, scb2_r;
  logic [MASS_W-1:0]  spa2_r, spb2_r;
  logic [DW+RW-1:0]   suma, sumb;

  always_comb begin
    suma = {pah1_r, LW'(0)} + (DW+RW)'(pal1_r);
    sumb = {pbh1_r, LW'(0)} + (DW+RW)'(pbl1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid2_r <= mid1_r;
      sca2_r <= suma[DW+QW-1:QW];
      scb2_r <= sumb[DW+QW-1:QW];
      spa2_r <= ppa1_r[MASS_W+QW-1:QW];
      spb2_r <= ppb1_r[MASS_W+QW-1:QW];
    end
  end

  // stage 3: impulse on the chosen axis, divide corrections by five
  logic                v3_r;
  acr_mid_t            mid3_r;
  logic signed [SX-1:0] newa3_r, newb3_r;
  logic [QPW-1:0]      qa3_r, qb3_r;
  logic signed [VEL_W-1:0] vsa, vsb;
  logic signed [SX-1:0] vae, vbe, sae, sbe, newa_nxt, newb_nxt;

  always_comb begin
    vsa = mid2_r.axis ? mid2_r.vay : mid2_r.vax;
    vsb = mid2_r.axis ? mid2_r.vby : mid2_r.vbx;
    vae = {{(SX-VEL_W){vsa[VEL_W-1]}}, vsa};
    vbe = {{(SX-VEL_W){vsb[VEL_W-1]}}, vsb};
    sae = mid2_r.apply ? {2'b00, sca2_r} : '0;
    sbe = mid2_r.apply ? {2'b00, scb2_r} : '0;
    newa_nxt = mid2_r.pos ? (vae - sae) : (vae + sae);
    newb_nxt = mid2_r.pos ? (vbe + sbe) : (vbe - sbe);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid3_r  <= mid2_r;
      newa3_r <= newa_nxt;
      newb3_r <= newb_nxt;
      qa3_r   <= spa2_r * DIV5_MUL;
      qb3_r   <= spb2_r * DIV5_MUL;
    end
  end

  // stage 4: saturate, sign the corrections and place them on the axis
  logic                    v4_r;
  logic                    hit4_r, stat4_r;
  logic [1:0]              code4_r;
  logic signed [VEL_W-1:0] pen4_r, vax4_r, vay4_r, vbx4_r, vby4_r;
  logic signed [VEL_W-1:0] sax4_r, say4_r, sbx4_r, sby4_r;
  logic signed [VEL_W-1:0] sata, satb, qa, qb, sha, shb;
  logic [SX-VEL_W:0]       topa, topb;

  always_comb begin
    topa = newa3_r[SX-1:VEL_W-1];
    topb = newb3_r[SX-1:VEL_W-1];
    if ((&topa) || !(|topa)) begin
      sata = newa3_r[VEL_W-1:0];
    end else begin
      sata = newa3_r[SX-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if ((&topb) || !(|topb)) begin
      satb = newb3_r[VEL_W-1:0];
    end else begin
      satb = newb3_r[SX-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    qa  = VEL_W'(qa3_r[QPW-1:DIV5_SHIFT]);
    qb  = VEL_W'(qb3_r[QPW-1:DIV5_SHIFT]);
    sha = mid3_r.corr ? (mid3_r.pos ? -qa : qa) : 32'sd0;
    shb = mid3_r.corr ? (mid3_r.pos ? qb : -qb) : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit4_r  <= mid3_r.hit;
      stat4_r <= mid3_r.stat;
      code4_r <= mid3_r.code;
      pen4_r  <= mid3_r.pen;
      vax4_r  <= mid3_r.axis ? mid3_r.vax : sata;
      vay4_r  <= mid3_r.axis ? sata : mid3_r.vay;
      vbx4_r  <= mid3_r.axis ? mid3_r.vbx : satb;
      vby4_r  <= mid3_r.axis ? satb : mid3_r.vby;
      sax4_r  <= mid3_r.axis ? 32'sd0 : sha;
      say4_r  <= mid3_r.axis ? sha : 32'sd0;
      sbx4_r  <= mid3_r.axis ? 32'sd0 : shb;
      sby4_r  <= mid3_r.axis ? shb : 32'sd0;
    end
  end

  assign out_valid       = v4_r;
  assign out_hit         = hit4_r;
  assign out_normal_code = code4_r;
  assign out_penetration = pen4_r;
  assign out_new_vel_a_x = vax4_r;
  assign out_new_vel_a_y = vay4_r;
  assign out_new_vel_b_x = vbx4_r;
  assign out_new_vel_b_y = vby4_r;
  assign out_shift_a_x   = sax4_r;
  assign out_shift_a_y   = say4_r;
  assign out_shift_b_x   = sbx4_r;
  assign out_shift_b_y   = sby4_r;
  assign out_both_static = stat4_r;

endmodule

[rtl/aabb_pair_collision_response_unit.sv]
`timescale 1ns / 1ps
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   box pair: offsets, extents, velocities, masses
// out_      output     out_valid/out_stall contact, new velocities, position corrections
//
// one item per cycle while no result waits under out_stall; 3 front stages,
// 30 divider stages for the inverse-mass share, one bit each, and 5 back stages
// synchronous active-low reset clears only the valid bits of every stage
// the whole pipeline holds while a result waits under out_stall; in_stall
// follows it in the same cycle, so no item is dropped or repeated
module aabb_pair_collision_response_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  input  logic [30:0]        in_extent_sum_x,
  input  logic [30:0]        in_extent_sum_y,
  input  logic signed [31:0] in_vel_a_x,
  input  logic signed [31:0] in_vel_a_y,
  input  logic signed [31:0] in_vel_b_x,
  input  logic signed [31:0] in_vel_b_y,
  input  logic [30:0]        in_mass_a,
  input  logic [30:0]        in_mass_b,
  input  logic [16:0]        in_bounce_a,
  input  logic [16:0]        in_bounce_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [1:0]         out_normal_code,
  output logic signed [31:0] out_penetration,
  output logic signed [31:0] out_new_vel_a_x,
  output logic signed [31:0] out_new_vel_a_y,
  output logic signed [31:0] out_new_vel_b_x,
  output logic signed [31:0] out_new_vel_b_y,
  output logic signed [31:0] out_shift_a_x,
  output logic signed [31:0] out_shift_a_y,
  output logic signed [31:0] out_shift_b_x,
  output logic signed [31:0] out_shift_b_y,
  output logic               out_both_static
);
  import acr_pkg::*;

  localparam int OW    = (FRACTION_BITS >= 17) ? FRACTION_BITS + 1 : 18;
  localparam int DW    = 33 + OW - FRACTION_BITS;
  localparam int TAG_W = $bits(acr_mid_t) + DW;

  // pipeline advance
  logic en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // front end
  logic              f_valid;
  acr_mid_t          f_mid;
  logic [DW-1:0]     f_d;
  logic [SUM_W-1:0]  f_sum;
  logic [MASS_W-1:0] f_mb;

  acr_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (in_valid),
    .in_offset_x     (in_offset_x),
    .in_offset_y     (in_offset_y),
    .in_extent_sum_x (in_extent_sum_x),
    .in_extent_sum_y (in_extent_sum_y),
    .in_vel_a_x      (in_vel_a_x),
    .in_vel_a_y      (in_vel_a_y),
    .in_vel_b_x      (in_vel_b_x),
    .in_vel_b_y      (in_vel_b_y),
    .in_mass_a       (in_mass_a),
    .in_mass_b       (in_mass_b),
    .in_bounce_a     (in_bounce_a),
    .in_bounce_b     (in_bounce_b),
    .out_valid       (f_valid),
    .out_mid         (f_mid),
    .out_d           (f_d),
    .out_sum         (f_sum),
    .out_mb          (f_mb)
  );

  // share divider, contact data rides along as a tag
  logic             dv_valid;
  logic [QW-1:0]    dv_quo;
  logic             dv_rem_nz;
  logic [TAG_W-1:0] dv_tag;
  acr_mid_t         dv_mid;

  acr_div #(
    .TAG_W (TAG_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (f_valid),
    .in_num     (f_mb),
    .in_den     (f_sum),
    .in_tag     ({f_mid, f_d}),
    .out_valid  (dv_valid),
    .out_quo    (dv_quo),
    .out_rem_nz (dv_rem_nz),
    .out_tag    (dv_tag)
  );

  assign dv_mid = acr_mid_t'(dv_tag[TAG_W-1:DW]);

  // impulse and correction back end
  acr_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (dv_valid),
    .in_mid          (dv_mid),
    .in_d            (dv_tag[DW-1:0]),
    .in_quo          (dv_quo),
    .in_rem_nz       (dv_rem_nz),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_normal_code (out_normal_code),
    .out_penetration (out_penetration),
    .out_new_vel_a_x (out_new_vel_a_x),
    .out_new_vel_a_y (out_new_vel_a_y),
    .out_new_vel_b_x (out_new_vel_b_x),
    .out_new_vel_b_y (out_new_vel_b_y),
    .out_shift_a_x   (out_shift_a_x),
    .out_shift_a_y   (out_shift_a_y),
    .out_shift_b_x   (out_shift_b_x),
    .out_shift_b_y   (out_shift_b_y),
    .out_both_static (out_both_static)
  );

endmodule

[dv/tb_aabb_pair_collision_response_unit.sv]
`timescale 1ns / 1ps
module tb_aabb_pair_collision_response_unit;
  import acr_pkg::*;

  localparam int FRAC = 16;
  localparam longint UNIT = 64'sd1 << FRAC;
  localparam longint SLOP = (UNIT + 50) / 100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic [30:0]        ex;
    logic [30:0]        ey;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic [30:0]        ma;
    logic [30:0]        mb;
    logic [16:0]        ba;
    logic [16:0]        bb;
  } box_pair_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         code;
    logic signed [31:0] pen;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [31:0] sax;
    logic signed [31:0] say;
    logic signed [31:0] sbx;
    logic signed [31:0] sby;
    logic               stat;
  } contact_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  box_pair_t drv;
  contact_t got;

  box_pair_t pending_pairs[$];
  contact_t  expected_contacts[$];
  int errors = 0;
  int sent = 0, received = 0;
  int idle_phase = 0;
  int hold_count = 0;
  bit hold_done = 0;
  int quiet_cycles = 0;

  aabb_pair_collision_response_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_offset_x(drv.ox), .in_offset_y(drv.oy),
    .in_extent_sum_x(drv.ex), .in_extent_sum_y(drv.ey),
    .in_vel_a_x(drv.vax), .in_vel_a_y(drv.vay),
    .in_vel_b_x(drv.vbx), .in_vel_b_y(drv.vby),
    .in_mass_a(drv.ma), .in_mass_b(drv.mb),
    .in_bounce_a(drv.ba), .in_bounce_b(drv.bb),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(got.hit), .out_normal_code(got.code), .out_penetration(got.pen),
    .out_new_vel_a_x(got.vax), .out_new_vel_a_y(got.vay),
    .out_new_vel_b_x(got.vbx), .out_new_vel_b_y(got.vby),
    .out_shift_a_x(got.sax), .out_shift_a_y(got.say),
    .out_shift_b_x(got.sbx), .out_shift_b_y(got.sby),
    .out_both_static(got.stat)
  );

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // floor(x * r / 2^30) without losing bits
  function automatic logic [63:0] share_of(logic [63:0] x, logic [63:0] r);
    logic [127:0] t;
    t = {64'd0, x} * {64'd0, r};
    return t[93:30];
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // expected contact response of one box pair
  function automatic contact_t resolve_pair(box_pair_t p);
    contact_t c;
    longint ox, oy, gx, gy, pen, rel, vn, sgn;
    longint va[2], vb[2], sa[2], sb[2];
    logic [63:0] ma, mb, ra, rb, e, d, depth;
    int ax;
    bit pos, hit, stat;
    ox = longint'(p.ox); oy = longint'(p.oy);
    va[0] = longint'(p.vax); va[1] = longint'(p.vay);
    vb[0] = longint'(p.vbx); vb[1] = longint'(p.vby);
    sa[0] = 0; sa[1] = 0; sb[0] = 0; sb[1] = 0;
    ma = 64'(p.ma); mb = 64'(p.mb);
    gx = (ox < 0 ? -ox : ox) - longint'(p.ex);
    gy = (oy < 0 ? -oy : oy) - longint'(p.ey);
    pen = 0; hit = 0; stat = 0; ax = 0; pos = 1;
    if (gx < 0 && gy < 0) begin
      hit = 1;
      if (gx > gy) begin
        ax = 0; pos = ox > 0; pen = gx;
      end else begin
        ax = 1; pos = oy > 0; pen = gy;
      end
      sgn = pos ? 64'sd1 : -64'sd1;
      if (ma == 0 && mb == 0) begin
        stat = 1;
      end else begin
        rel = vb[ax] - va[ax];
        vn = pos ? rel : -rel;
        if (vn <= 0) begin
          if (ma == 0) begin
            ra = 0; rb = 64'd1 << 30;
          end else if (mb == 0) begin
            ra = 64'd1 << 30; rb = 0;
          end else begin
            ra = (mb << 30) / (ma + mb);
            rb = (ma << 30) / (ma + mb);
          end
          e = (p.ba < p.bb) ? 64'(p.ba) : 64'(p.bb);
          d = (64'(-vn) * (64'(UNIT) + e)) >> FRAC;
          va[ax] = va[ax] - sgn * longint'(share_of(d, ra));
          vb[ax] = vb[ax] + sgn * longint'(share_of(d, rb));
          depth = 64'(-pen);
          if (depth > 64'(SLOP)) begin
            sa[ax] = -sgn * longint'(share_of(depth, ra) / 5);
            sb[ax] = sgn * longint'(share_of(depth, rb) / 5);
          end
        end
      end
    end
    c.hit = hit;
    c.code = hit ? (pos ? (ax ? NRM_POS_Y : NRM_POS_X) : (ax ? NRM_NEG_Y : NRM_NEG_X))
                 : NRM_POS_X;
    c.pen = pen[31:0];
    c.vax = clamp32(va[0]); c.vay = clamp32(va[1]);
    c.vbx = clamp32(vb[0]); c.vby = clamp32(vb[1]);
    c.sax = clamp32(sa[0]); c.say = clamp32(sa[1]);
    c.sbx = clamp32(sb[0]); c.sby = clamp32(sb[1]);
    c.stat = stat;
    return c;
  endfunction

  task automatic report(string field, longint g, longint x);
    $display("mismatch on item %0d, %s: got %0d, expected %0d", received, field, g, x);
    errors++;
  endtask

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(0, 3))
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 32'h7fff)) - 32'sd16384;
      default: return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh1ffffff;
    endcase
  endfunction

  function automatic logic [30:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'($urandom);
      default: return 31'($urandom_range(1, 32'h7fffff));
    endcase
  endfunction

  // offset inside a nonzero extent, so the pair overlaps on that axis
  function automatic logic signed [31:0] rand_offset(logic [30:0] ext);
    longint m;
    if ($urandom_range(0, 15) == 0) return 0;
    if (ext == 0) return $signed($urandom);
    m = longint'($urandom) % longint'(ext);
    return $urandom_range(0, 1) ? m[31:0] : -m[31:0];
  endfunction

  function automatic box_pair_t rand_pair();
    box_pair_t p;
    if ($urandom_range(0, 3) == 0) begin
      // noise: every field fully random
      p.ox = $urandom; p.oy = $urandom;
      p.ex = 31'($urandom); p.ey = 31'($urandom);
      p.vax = $urandom; p.vay = $urandom; p.vbx = $urandom; p.vby = $urandom;
      p.ma = 31'($urandom); p.mb = 31'($urandom);
      p.ba = 17'($urandom); p.bb = 17'($urandom);
    end else begin
      p.ex = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(1, 32'hfffff));
      p.ey = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(1, 32'hfffff));
      p.ox = rand_offset(p.ex);
      p.oy = rand_offset(p.ey);
      p.vax = rand_vel(); p.vay = rand_vel(); p.vbx = rand_vel(); p.vby = rand_vel();
      p.ma = rand_mass(); p.mb = rand_mass();
      p.ba = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      p.bb = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    end
    return p;
  endfunction

  function automatic box_pair_t mk(longint ox, longint oy, longint ex, longint ey,
                                   longint vax, longint vay, longint vbx, longint vby,
                                   longint ma, longint mb, longint ba, longint bb);
    box_pair_t p;
    p.ox = 32'(ox); p.oy = 32'(oy); p.ex = 31'(ex); p.ey = 31'(ey);
    p.vax = 32'(vax); p.vay = 32'(vay); p.vbx = 32'(vbx); p.vby = 32'(vby);
    p.ma = 31'(ma); p.mb = 31'(mb); p.ba = 17'(ba); p.bb = 17'(bb);
    return p;
  endfunction

  // append one pair to the pending list
  function automatic void queue_pair(box_pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // stimulus and end of run
  initial begin
    rst_n = 0;
    // no overlap on either axis, and on one axis only
    queue_pair(mk(5*UNIT, 5*UNIT, UNIT, UNIT, 1, 2, 3, 4, UNIT, UNIT, 0, 0));
    queue_pair(mk(UNIT/2, 5*UNIT, UNIT, UNIT, 1, 2, 3, 4, UNIT, UNIT, 0, 0));
    // least overlap on x, plus and minus, approaching
    queue_pair(mk(UNIT*3/2, 0, 2*UNIT, 4*UNIT, UNIT, 0, -UNIT, 0,
                  UNIT, 2*UNIT, 65536, 32768));
    queue_pair(mk(-UNIT*3/2, UNIT, 2*UNIT, 4*UNIT, -UNIT, 0, UNIT, 0,
                  3*UNIT, UNIT, 0, 65536));
    // least overlap on y, plus and minus
    queue_pair(mk(0, UNIT*3/2, 4*UNIT, 2*UNIT, 0, UNIT, 0, -UNIT,
                  UNIT, UNIT, 65536, 65536));
    queue_pair(mk(UNIT, -UNIT*3/2, 4*UNIT, 2*UNIT, 0, -UNIT, 0, UNIT,
                  UNIT, UNIT, 20000, 40000));
    // tie between axes, and zero offsets
    queue_pair(mk(UNIT, UNIT, 2*UNIT, 2*UNIT, UNIT, UNIT, 0, 0,
                  UNIT, UNIT, 0, 0));
    queue_pair(mk(0, 0, UNIT, UNIT, 0, -UNIT, 0, UNIT, UNIT, UNIT, 0, 0));
    queue_pair(mk(0, UNIT/4, UNIT, UNIT, 0, 0, 0, 0, UNIT, UNIT, 0, 0));
    // both static, static a, static b
    queue_pair(mk(UNIT/2, 0, UNIT, 4*UNIT, UNIT, 0, -UNIT, 0, 0, 0, 0, 0));
    queue_pair(mk(UNIT/2, 0, UNIT, 4*UNIT, UNIT, 0, -UNIT, 0, 0, UNIT, 65536, 65536));
    queue_pair(mk(UNIT/2, 0, UNIT, 4*UNIT, UNIT, 0, -UNIT, 0, UNIT, 0, 65536, 65536));
    // separating pair
    queue_pair(mk(UNIT/2, 0, UNIT, 4*UNIT, -UNIT, 0, UNIT, 0, UNIT, UNIT, 0, 0));
    // shallow penetration at and just past the slop
    queue_pair(mk(UNIT - SLOP, 0, UNIT, 4*UNIT, UNIT, 0, 0, 0, UNIT, UNIT, 0, 0));
    queue_pair(mk(UNIT - SLOP - 1, 0, UNIT, 4*UNIT, UNIT, 0, 0, 0, UNIT, UNIT, 0, 0));
    // zero relative velocity
    queue_pair(mk(UNIT/2, 0, UNIT, 4*UNIT, 7, 0, 7, 0, UNIT, UNIT, 0, 0));
    // extremes: saturating velocities, largest extents and masses, bounce above one
    queue_pair(mk(1, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -32'sh80000000,
                  -32'sh80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  131071, 131071));
    queue_pair(mk(-32'sh80000000 + 1, -32'sh80000000 + 2, 32'h7fffffff,
                  32'h7fffffff, -32'sh80000000, 32'h7fffffff, 32'h7fffffff,
                  -32'sh80000000, 1, 32'h7fffffff, 131071, 131071));
    queue_pair(mk(-32'sh80000000, -32'sh80000000, 32'h7fffffff, 32'h7fffffff,
                  0, 0, 0, 0, 0, 0, 0, 0));
    queue_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_pair(mk(32'h7fffffff, 0, 32'h7fffffff, 1, 0, 0, 0, 0, 1, 1, 1, 0));
    repeat (700) queue_pair(rand_pair());
    repeat (4) @(posedge clk);
    rst_n <= 1;
    wait (pending_pairs.size() == 0 && !in_valid);
    wait (expected_contacts.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("tb_aabb_pair_collision_response_unit passed");
    else
      $display("tb_aabb_pair_collision_response_unit failed");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      drv <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_contacts.insert(expected_contacts.size(), resolve_pair(drv));
        sent++;
      end
      idle_phase = (sent / 90) % 4;
      if (pending_pairs.size() > 0 &&
          !((idle_phase == 1 && $urandom_range(0, 99) < 67) ||
            (idle_phase == 3 && $urandom_range(0, 99) < 14))) begin
        drv <= pending_pairs.pop_front();
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor and receiver stall, with one long hold-off
  always @(posedge clk) begin
    contact_t x;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_contacts.size() == 0) begin
          $display("unexpected result item %0d", received);
          errors++;
        end else begin
          x = expected_contacts.pop_front();
          if (got.hit !== x.hit) report("hit", got.hit, x.hit);
          if (got.code !== x.code) report("normal_code", got.code, x.code);
          if (got.pen !== x.pen) report("penetration", got.pen, x.pen);
          if (got.vax !== x.vax) report("new_vel_a_x", got.vax, x.vax);
          if (got.vay !== x.vay) report("new_vel_a_y", got.vay, x.vay);
          if (got.vbx !== x.vbx) report("new_vel_b_x", got.vbx, x.vbx);
          if (got.vby !== x.vby) report("new_vel_b_y", got.vby, x.vby);
          if (got.sax !== x.sax) report("shift_a_x", got.sax, x.sax);
          if (got.say !== x.say) report("shift_a_y", got.say, x.say);
          if (got.sbx !== x.sbx) report("shift_b_x", got.sbx, x.sbx);
          if (got.sby !== x.sby) report("shift_b_y", got.sby, x.sby);
          if (got.stat !== x.stat) report("both_static", got.stat, x.stat);
        end
        received++;
      end
      if (!hold_done && received >= 40) begin
        hold_count <= hold_count + 1;
        if (hold_count + 1 >= HOLD_CYCLES) hold_done <= 1;
        out_stall <= 1;
      end else begin
        out_stall <= ((idle_phase == 2 && $urandom_range(0, 99) < 67) ||
                      (idle_phase == 3 && $urandom_range(0, 99) < 14));
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_aabb_pair_collision_response_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[sim.f]
rtl/acr_pkg.sv
rtl/acr_front.sv
rtl/acr_div.sv
rtl/acr_back.sv
rtl/aabb_pair_collision_response_unit.sv
dv/tb_aabb_pair_collision_response_unit.sv
